@@ src/sorted_insertion_buffer_core_assert.svh @@
// Assertion macros for the sorted insertion buffer RTL.
`ifndef SORTED_INSERTION_BUFFER_CORE_ASSERT_SVH
`define SORTED_INSERTION_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sib assertion failed");

// Next-cycle implication, checked outside reset.
`define SIB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sib assertion failed");

`endif

@@ src/sib_pkg.sv @@
// Shared types and constants of the sorted insertion buffer.
package sib_pkg;

    localparam int KEY_W     = 16;
    localparam int PAY_W     = 32;
    localparam int FILL_W    = 11;
    localparam int DEPTH_DEF = 1024;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_cmd;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic             occ;
        logic             gt;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_link;

endpackage

@@ src/sorted_insertion_buffer_core.sv @@
// Top level of the sorted insertion buffer: a row of record cells with a result register.
//
//  Channel   Dir  tdata (low bit up)                        tuser
//  s_axis    in   key[15:0], payload[47:16]                 opcode (0 insert, 1 pop)
//  m_axis    out  out_key[15:0], out_payload[47:16],        status (0 done, 1 full,
//                 fill[58:48], zero[63:59]                          2 empty)
//
// Each beat is handled in the cycle it is accepted; one beat per cycle is sustained.
// The whole row of DEPTH cells shifts in that one cycle, steered by a per-cell compare.
// The result is registered and offered on the cycle after its beat is accepted.
// While that result waits on a stalled output, the input is held off.
// Reset is synchronous, active low; it empties the row and clears the count.
`include "sorted_insertion_buffer_core_assert.svh"

module sorted_insertion_buffer_core #(
    parameter int DEPTH = sib_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // key[15:0], payload[47:16]
    input  logic [sib_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_key[15:0], out_payload[47:16], fill[58:48], zeros[63:59]
    output logic [sib_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                     o_m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    sib_pkg::t_link w_link [DEPTH];
    sib_pkg::t_link w_head;
    sib_pkg::t_link w_tail;
    sib_pkg::t_cmd  w_cmd;

    logic                         w_fire;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_is_pop;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_out_valid;
    logic [sib_pkg::KEY_W-1:0]    r_out_key;
    logic [sib_pkg::KEY_W-1:0]    n_out_key;
    logic [sib_pkg::PAY_W-1:0]    r_out_payload;
    logic [sib_pkg::PAY_W-1:0]    n_out_payload;
    sib_pkg::t_status             r_out_status;
    sib_pkg::t_status             n_out_status;
    logic [sib_pkg::FILL_W-1:0]   r_out_fill;

    // Handshake: accept whenever the result register is free or draining.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_pop        = (sib_pkg::t_op'(i_s_axis_tuser) == sib_pkg::OP_POP);

    // The row is full when its last cell is occupied, empty when its first is not.
    assign w_full  = w_link[DEPTH-1].occ;
    assign w_empty = !w_link[0].occ;

    assign w_cmd.ins     = w_fire && !w_is_pop && !w_full;
    assign w_cmd.pop     = w_fire && w_is_pop && !w_empty;
    assign w_cmd.key     = i_s_axis_tdata[sib_pkg::KEY_W-1:0];
    assign w_cmd.payload = i_s_axis_tdata[sib_pkg::KEY_W +: sib_pkg::PAY_W];

    // Boundary links: the head acts as an occupied slot that never moves up,
    // the tail as an empty slot.
    assign w_head = '{occ: 1'b1, gt: 1'b0, key: '0, payload: '0};
    assign w_tail = '{occ: 1'b0, gt: 1'b0, key: '0, payload: '0};

    // Row of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sib_pkg::t_link w_l;
        sib_pkg::t_link w_r;
        if (g == 0) begin : g_first
            assign w_l = w_head;
        end else begin : g_mid_l
            assign w_l = w_link[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_r = w_tail;
        end else begin : g_mid_r
            assign w_r = w_link[g+1];
        end
        sib_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_l),
            .i_right (w_r),
            .o_link  (w_link[g])
        );
    end

    // Result of the accepted beat and the new record count.
    always_comb begin
        n_count       = r_count;
        n_out_key     = '0;
        n_out_payload = '0;
        n_out_status  = sib_pkg::ST_DONE;
        if (w_is_pop) begin
            if (w_empty) begin
                n_out_status = sib_pkg::ST_EMPTY;
            end else begin
                n_out_key     = w_link[0].key;
                n_out_payload = w_link[0].payload;
                n_count       = r_count - 1'b1;
            end
        end else begin
            if (w_full) begin
                n_out_status = sib_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_key     <= n_out_key;
            r_out_payload <= n_out_payload;
            r_out_status  <= n_out_status;
            r_out_fill    <= sib_pkg::FILL_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {5'b0, r_out_fill, r_out_payload, r_out_key};

    // The count and the occupancy of the end cells must agree.
    `SIB_ASSERT_NOW(a_head_occ, i_clk, i_rst_n, 1'b1, w_link[0].occ == (r_count != '0))
    `SIB_ASSERT_NOW(a_tail_occ, i_clk, i_rst_n, 1'b1,
        w_link[DEPTH-1].occ == (r_count == CW'(DEPTH)))
    // A refused insert leaves the count alone.
    `SIB_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, w_fire && !w_is_pop && w_full,
        r_count == $past(r_count) && r_out_status == sib_pkg::ST_FULL)
    // A pop from a non-empty row completes and shrinks the count by one.
    `SIB_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, w_fire && w_is_pop && !w_empty,
        r_count == CW'($past(r_count) - 1'b1) && r_out_status == sib_pkg::ST_DONE)

endmodule

@@ src/sib_cell.sv @@
// One slot of the sorted row: holds a record and shifts it left or right.
module sib_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sib_pkg::t_cmd  i_cmd,
    input  sib_pkg::t_link i_left,
    input  sib_pkg::t_link i_right,
    output sib_pkg::t_link o_link
);

    logic                      r_occ;
    logic                      n_occ;
    logic [sib_pkg::KEY_W-1:0] r_key;
    logic [sib_pkg::KEY_W-1:0] n_key;
    logic [sib_pkg::PAY_W-1:0] r_payload;
    logic [sib_pkg::PAY_W-1:0] n_payload;
    logic                      w_gt;

    // A stored key larger than the new one must move up on insert.
    assign w_gt = r_occ && (r_key > i_cmd.key);

    assign o_link.occ     = r_occ;
    assign o_link.gt      = w_gt;
    assign o_link.key     = r_key;
    assign o_link.payload = r_payload;

    // Insert: take the left record if it moves up, else the new record if this
    // is its slot. Pop: everything moves one place toward the head.
    always_comb begin
        n_occ     = r_occ;
        n_key     = r_key;
        n_payload = r_payload;
        if (i_cmd.ins) begin
            if (i_left.gt) begin
                n_occ     = 1'b1;
                n_key     = i_left.key;
                n_payload = i_left.payload;
            end else if (w_gt || (!r_occ && i_left.occ)) begin
                n_occ     = 1'b1;
                n_key     = i_cmd.key;
                n_payload = i_cmd.payload;
            end
        end else if (i_cmd.pop) begin
            n_occ     = i_right.occ;
            n_key     = i_right.key;
            n_payload = i_right.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Record contents need no reset; only occupied slots are ever read.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the sorted insertion buffer: directed table, then a random walk.
`timescale 1ns / 100ps

module testbench;

    localparam int ROW_DEPTH   = sib_pkg::DEPTH_DEF;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 48;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    // One stored record of the shadow row.
    typedef struct packed {
        logic [sib_pkg::KEY_W-1:0] key;
        logic [sib_pkg::PAY_W-1:0] payload;
    } t_rec;

    // Fields of one result beat.
    typedef struct packed {
        logic [sib_pkg::KEY_W-1:0]  key;
        logic [sib_pkg::PAY_W-1:0]  payload;
        sib_pkg::t_status           status;
        logic [sib_pkg::FILL_W-1:0] fill;
    } t_outcome;

    // One row of the directed table.
    typedef struct {
        sib_pkg::t_op              op;
        logic [sib_pkg::KEY_W-1:0] key;
        logic [sib_pkg::PAY_W-1:0] payload;
        bit                        typed;
        t_outcome                  want;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [sib_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                           i_s_axis_tuser;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [sib_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [1:0]                     o_m_axis_tuser;

    t_rec     shadow_row[$];
    t_outcome pending_results[$];
    t_dir_row dir_rows[$];
    t_outcome offer_result;

    bit hold_req;
    int burst_left;
    int mismatches;
    int idle_cycles;
    int beats_in;
    int beats_out;
    int inserts_done;
    int inserts_refused;
    int pops_done;
    int pops_empty;
    int peak_fill;
    int holds_done;

    sorted_insertion_buffer_core #(
        .DEPTH(ROW_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Free-running clock, 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one beat to the shadow row and returns the result it must produce.
    // Inserts land after every record whose key is not greater, so equal keys stay in
    // arrival order; pops take the front record.
    function automatic t_outcome sort_step(input sib_pkg::t_op op,
                                           input logic [sib_pkg::KEY_W-1:0] key,
                                           input logic [sib_pkg::PAY_W-1:0] payload);
        t_outcome res;
        t_rec     rec;
        int       pos;
        res = '0;
        res.status = sib_pkg::ST_DONE;
        if (op == sib_pkg::OP_INSERT) begin
            if (shadow_row.size() >= ROW_DEPTH) begin
                res.status = sib_pkg::ST_FULL;
            end else begin
                pos = shadow_row.size();
                while (pos > 0 && shadow_row[pos-1].key > key) pos--;
                rec.key = key;
                rec.payload = payload;
                shadow_row.insert(pos, rec);
            end
        end else if (shadow_row.size() == 0) begin
            res.status = sib_pkg::ST_EMPTY;
        end else begin
            rec = shadow_row.pop_front();
            res.key = rec.key;
            res.payload = rec.payload;
        end
        res.fill = sib_pkg::FILL_W'(shadow_row.size());
        return res;
    endfunction

    function automatic logic [sib_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sib_pkg::KEY_W'($urandom_range(0, 7));
            4:          return ($urandom_range(0, 1) == 1) ? '1 : '0;
            5:          return sib_pkg::KEY_W'($urandom_range(65528, 65535));
            default:    return sib_pkg::KEY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [sib_pkg::PAY_W-1:0] pick_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Table row whose result comes from the predictor.
    task automatic add_row(input sib_pkg::t_op op, input logic [sib_pkg::KEY_W-1:0] key,
                           input logic [sib_pkg::PAY_W-1:0] payload);
        t_dir_row row;
        row.op = op;
        row.key = key;
        row.payload = payload;
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    // Table row with its result written out by hand.
    task automatic add_typed(input sib_pkg::t_op op, input logic [sib_pkg::KEY_W-1:0] key,
                             input logic [sib_pkg::PAY_W-1:0] payload,
                             input logic [sib_pkg::KEY_W-1:0] w_key,
                             input logic [sib_pkg::PAY_W-1:0] w_payload,
                             input sib_pkg::t_status w_status, input int w_fill);
        t_dir_row row;
        row.op = op;
        row.key = key;
        row.payload = payload;
        row.typed = 1'b1;
        row.want.key = w_key;
        row.want.payload = w_payload;
        row.want.status = w_status;
        row.want.fill = sib_pkg::FILL_W'(w_fill);
        dir_rows.push_back(row);
    endtask

    // Offers one beat, maybe after a gap if a burst has run out, and returns once it is taken.
    task automatic send_beat(input sib_pkg::t_op op, input logic [sib_pkg::KEY_W-1:0] key,
                             input logic [sib_pkg::PAY_W-1:0] payload, input bit typed,
                             input t_outcome want);
        t_outcome predicted;
        int       gap;
        predicted = sort_step(op, key, payload);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        offer_result = typed ? want : predicted;
        i_s_axis_tdata = {payload, key};
        i_s_axis_tuser = op;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random(input int pop_pct);
        sib_pkg::t_op op;
        op = ($urandom_range(1, 100) <= pop_pct) ? sib_pkg::OP_POP : sib_pkg::OP_INSERT;
        send_beat(op, pick_key(), pick_payload(), 1'b0, '0);
    endtask

    // Result side: stalls on a random pattern, picked anew after each random span, and holds
    // off entirely for a long stretch whenever the stimulus asks for it.
    initial begin
        int mode;
        int span;
        int phase;
        i_m_axis_tready = 1'b0;
        mode = 0;
        span = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                phase++;
                case (mode)
                    0:       i_m_axis_tready = 1'b1;
                    1:       i_m_axis_tready = ($urandom_range(0, 1) == 1);
                    2:       i_m_axis_tready = (phase % 4 != 3);
                    default: i_m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Scoreboard: records accepted beats, checks each result against the oldest
    // expectation, and ends the run if the bus goes quiet for too long.
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_results.push_back(offer_result);
                beats_in++;
                case (offer_result.status)
                    sib_pkg::ST_FULL:  inserts_refused++;
                    sib_pkg::ST_EMPTY: pops_empty++;
                    default: begin
                        if (i_s_axis_tuser == sib_pkg::OP_INSERT) inserts_done++;
                        else pops_done++;
                    end
                endcase
                if (int'(offer_result.fill) > peak_fill) peak_fill = int'(offer_result.fill);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                beats_out++;
                got.key = o_m_axis_tdata[15:0];
                got.payload = o_m_axis_tdata[47:16];
                got.fill = o_m_axis_tdata[58:48];
                got.status = sib_pkg::t_status'(o_m_axis_tuser);
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result beat with nothing expected: key %h payload %h",
                                 $realtime, got.key, got.payload);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want || o_m_axis_tdata[63:59] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result %0d: expected key %h payload %h ",
                                      "status %0d fill %0d, got key %h payload %h ",
                                      "status %0d fill %0d pad %b"},
                                     $realtime, beats_out, want.key, want.payload,
                                     want.status, want.fill, got.key, got.payload,
                                     o_m_axis_tuser, got.fill, o_m_axis_tdata[63:59]);
                    end
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending_results.size());
                $display("sorted_insertion_buffer_core verification failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = sib_pkg::OP_INSERT;
        hold_req = 1'b0;
        burst_left = 0;
        offer_result = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: empty pops, extreme keys and tags, equal keys leaving in order.
        add_typed(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000, '0, '0, sib_pkg::ST_EMPTY, 0);
        add_typed(sib_pkg::OP_POP,    16'hFFFF, 32'hFFFF_FFFF, '0, '0, sib_pkg::ST_EMPTY, 0);
        add_typed(sib_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, sib_pkg::ST_DONE, 1);
        add_typed(sib_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, '0, '0, sib_pkg::ST_DONE, 2);
        add_typed(sib_pkg::OP_INSERT, 16'h0005, 32'h0000_000A, '0, '0, sib_pkg::ST_DONE, 3);
        add_typed(sib_pkg::OP_INSERT, 16'h0005, 32'h0000_000B, '0, '0, sib_pkg::ST_DONE, 4);
        add_typed(sib_pkg::OP_INSERT, 16'h0005, 32'h0000_000C, '0, '0, sib_pkg::ST_DONE, 5);
        add_typed(sib_pkg::OP_INSERT, 16'h0003, 32'h0000_000D, '0, '0, sib_pkg::ST_DONE, 6);
        add_typed(sib_pkg::OP_INSERT, 16'h8000, 32'h8000_0000, '0, '0, sib_pkg::ST_DONE, 7);
        add_typed(sib_pkg::OP_INSERT, 16'h7FFF, 32'h7FFF_FFFF, '0, '0, sib_pkg::ST_DONE, 8);
        add_typed(sib_pkg::OP_POP,    16'h1234, 32'h5678_9ABC, '0, '0, sib_pkg::ST_DONE, 7);
        add_row(sib_pkg::OP_POP,    16'hFFFF, 32'hFFFF_FFFF);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        add_row(sib_pkg::OP_POP,    16'hA5A5, 32'h5A5A_5A5A);
        add_row(sib_pkg::OP_INSERT, 16'h0005, 32'h0000_000E);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        add_typed(sib_pkg::OP_POP,  16'h0000, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF,
                  sib_pkg::ST_DONE, 0);
        add_typed(sib_pkg::OP_POP,  16'h0000, 32'h0000_0000, '0, '0, sib_pkg::ST_EMPTY, 0);
        add_row(sib_pkg::OP_INSERT, 16'hAAAA, 32'h5555_5555);
        add_row(sib_pkg::OP_INSERT, 16'h5555, 32'hAAAA_AAAA);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        add_row(sib_pkg::OP_POP,    16'h0000, 32'h0000_0000);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].key, dir_rows[i].payload,
                      dir_rows[i].typed, dir_rows[i].want);

        // Mixed traffic around a near-empty row; the result side holds off once partway through.
        for (n = 0; n < 200; n++) begin
            if (n == 60) hold_req = 1'b1;
            send_random(50);
        end

        // Fill the row to the top, keep pushing until a dozen inserts are refused,
        // and stall the result side once more on the way up.
        n = 0;
        while (inserts_refused < 12 || pending_results.size() > 0 && inserts_refused == 0) begin
            if (n == 500) hold_req = 1'b1;
            send_random(3);
            n++;
            if (inserts_refused >= 12) break;
        end

        // Drain mostly, with inserts mixed in.
        for (n = 0; n < 400; n++) send_random(80);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d inserts placed, %0d refused on a full row",
                 beats_in, inserts_done, inserts_refused);
        $display("%0d records popped, %0d pops on an empty row, peak fill %0d, %0d long holds",
                 pops_done, pops_empty, peak_fill, holds_done);
        if (mismatches == 0) begin
            $display("sorted_insertion_buffer_core verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sorted_insertion_buffer_core verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/sib_pkg.sv
src/sib_cell.sv
src/sorted_insertion_buffer_core.sv
bench/testbench.sv
